// ===== rtl/ftrm_pkg.sv =====
// Shared widths, constants and register codes for the fan tachometer rpm meter.
`timescale 1ns / 1ps

package ftrm_pkg;

    // Field and state widths.
    localparam int DEBOUNCE_W = 16;
    localparam int WINDOW_W   = 24;
    localparam int COUNT_W    = 16;
    localparam int RPM_W      = 21;
    localparam int SUM_W      = 24;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index codes, taken from paddr[2].
    localparam logic [0:0] REG_DEBOUNCE = 1'b0;
    localparam logic [0:0] REG_WINDOW   = 1'b1;

    // Register reset values.
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd800;
    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 24'd1000000;

    // Division by five as multiply by ceil(2^26 / 5) and shift by 26.
    // The error term is 1, so the quotient is exact for any sum below 2^26.
    localparam int               DIV5_SHIFT = 26;
    localparam logic [SUM_W-1:0] DIV5_RECIP = 24'd13421773;

endpackage

// ===== rtl/ftrm_blend.sv =====
// Smoothing step: raw rpm from the pulse count, blended 2/5 old and 3/5 new.
`timescale 1ns / 1ps

module ftrm_blend (
    input  logic [ftrm_pkg::RPM_W-1:0]   i_old_rpm,
    input  logic [ftrm_pkg::COUNT_W-1:0] i_edge_count,
    output logic [ftrm_pkg::RPM_W-1:0]   o_new_rpm
);

    logic [ftrm_pkg::RPM_W-1:0]   w_raw;
    logic [ftrm_pkg::SUM_W-1:0]   w_sum;
    logic [2*ftrm_pkg::SUM_W-1:0] w_prod;
    logic [ftrm_pkg::RPM_W-1:0]   w_quot;

    // Two pulses per revolution: raw rpm is count * 30 = count * 32 - count * 2.
    assign w_raw = ({i_edge_count, 5'b0} - {4'b0, i_edge_count, 1'b0});

    // Weighted sum 2 * old + 3 * raw, which stays below 2^24.
    assign w_sum = {2'b0, i_old_rpm, 1'b0}
                 + {2'b0, w_raw, 1'b0}
                 + {3'b0, w_raw};

    // Floor of the sum divided by five through the reciprocal.
    assign w_prod = {{ftrm_pkg::SUM_W{1'b0}}, w_sum}
                  * {{ftrm_pkg::SUM_W{1'b0}}, ftrm_pkg::DIV5_RECIP};
    assign w_quot = w_prod[ftrm_pkg::DIV5_SHIFT +: ftrm_pkg::RPM_W];

    // A zero smoothed value is seeded straight from the raw reading.
    assign o_new_rpm = (i_old_rpm == '0) ? w_raw : w_quot;

endmodule

// ===== rtl/fan_tach_rpm_meter_unit.sv =====
// Fan tachometer top level: tick channel, rpm result channel and register port.
`timescale 1ns / 1ps

// Each input transaction is one microsecond tick with a flag for a falling
// tach edge. The unit takes one tick in every clock cycle when not stalled
// and returns exactly one result per tick, in the cycle after acceptance,
// carrying the smoothed rpm and a flag marking the measurement window's last tick.
// The debounce counter, window counter, pulse count and smoothed value are
// all updated in the cycle a tick is accepted; the longest path is the
// divide-by-five reciprocal multiply of the smoothing step. The result sits
// in an output register, so a new tick is still taken while a result waits,
// and ticks stall only when that result is held up and a new one would
// overwrite it. Registers: debounce_us at byte address 0, window_us at 4.
module fan_tach_rpm_meter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Tick channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_tach_falling,
    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ftrm_pkg::RPM_W-1:0]     o_rpm,
    output logic                           o_rpm_updated,
    // Register port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ftrm_pkg::PADDR_W-1:0]   paddr,
    input  logic [ftrm_pkg::PDATA_W-1:0]   pwdata,
    output logic [ftrm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [ftrm_pkg::DEBOUNCE_W-1:0] r_debounce;
    logic [ftrm_pkg::WINDOW_W-1:0]   r_window;

    logic [ftrm_pkg::DEBOUNCE_W-1:0] r_since_edge, n_since_edge;
    logic [ftrm_pkg::COUNT_W-1:0]    r_edge_count, n_edge_count;
    logic [ftrm_pkg::WINDOW_W-1:0]   r_win_elapsed, n_win_elapsed;
    logic [ftrm_pkg::RPM_W-1:0]      r_smoothed, n_smoothed;

    logic                            r_out_valid;
    logic [ftrm_pkg::RPM_W-1:0]      r_rpm;
    logic                            r_rpm_updated;

    logic                            w_in_fire;
    logic                            w_cfg_write;
    logic                            w_saturated;
    logic [ftrm_pkg::DEBOUNCE_W-1:0] w_elapsed;
    logic                            w_counted;
    logic [ftrm_pkg::WINDOW_W:0]     w_win_next;
    logic                            w_closing;
    logic [ftrm_pkg::RPM_W-1:0]      w_blend_rpm;

    // Register writes and reads; the port never inserts wait states.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= ftrm_pkg::DEBOUNCE_RESET;
            r_window   <= ftrm_pkg::WINDOW_RESET;
        end else if (w_cfg_write) begin
            case (paddr[2])
                ftrm_pkg::REG_DEBOUNCE: r_debounce <= pwdata[ftrm_pkg::DEBOUNCE_W-1:0];
                ftrm_pkg::REG_WINDOW:   r_window   <= pwdata[ftrm_pkg::WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ftrm_pkg::REG_DEBOUNCE:
                prdata = {{(ftrm_pkg::PDATA_W-ftrm_pkg::DEBOUNCE_W){1'b0}}, r_debounce};
            ftrm_pkg::REG_WINDOW:
                prdata = {{(ftrm_pkg::PDATA_W-ftrm_pkg::WINDOW_W){1'b0}}, r_window};
            default:
                prdata = '0;
        endcase
    end

    // Handshake: a tick is refused only while a finished result is held up.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_fire  = i_in_valid && !o_in_stall;

    // Debounce: an edge counts if none has counted yet or enough time has passed.
    assign w_saturated = (r_since_edge == '1);
    assign w_elapsed   = w_saturated ? r_since_edge : (r_since_edge + 16'd1);
    assign w_counted   = i_tach_falling && (w_saturated || (w_elapsed > r_debounce));

    // Window close. The incremented count is never zero, so a window length
    // of zero closes on every tick just like a length of one.
    assign w_win_next = {1'b0, r_win_elapsed} + {{ftrm_pkg::WINDOW_W{1'b0}}, 1'b1};
    assign w_closing  = (w_win_next >= {1'b0, r_window});

    ftrm_blend u_blend (
        .i_old_rpm    (r_smoothed),
        .i_edge_count (r_edge_count),
        .o_new_rpm    (w_blend_rpm)
    );

    // Next state for one tick. The closing tick's own edge opens the next window.
    always_comb begin
        n_since_edge  = w_counted ? '0 : w_elapsed;
        n_smoothed    = r_smoothed;
        n_edge_count  = r_edge_count;
        n_win_elapsed = w_win_next[ftrm_pkg::WINDOW_W-1:0];
        if (w_closing) begin
            n_smoothed    = w_blend_rpm;
            n_edge_count  = {{(ftrm_pkg::COUNT_W-1){1'b0}}, w_counted};
            n_win_elapsed = '0;
        end else if (w_counted && (r_edge_count != '1)) begin
            n_edge_count = r_edge_count + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since_edge  <= '1;
            r_edge_count  <= '0;
            r_win_elapsed <= '0;
            r_smoothed    <= '0;
        end else if (w_in_fire) begin
            r_since_edge  <= n_since_edge;
            r_edge_count  <= n_edge_count;
            r_win_elapsed <= n_win_elapsed;
            r_smoothed    <= n_smoothed;
        end
    end

    // Output register: loaded on each accepted tick, cleared once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_rpm         <= n_smoothed;
            r_rpm_updated <= w_closing;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rpm         = r_rpm;
    assign o_rpm_updated = r_rpm_updated;

    // A pending result always shows the current smoothed value.
    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rpm == r_smoothed))
        else $error("pending rpm differs from smoothed state");

    // The smoothed value moves only on a tick that closes the window.
    a_smoothed_only_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_fire && w_closing) |=> $stable(r_smoothed))
        else $error("smoothed rpm changed without a window close");

    // A closing tick restarts the window with at most its own edge counted.
    a_window_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_closing) |=> ((r_win_elapsed == '0) && (r_edge_count <= 16'd1)))
        else $error("window did not restart on close");

    // Every accepted tick leaves a result pending in the next cycle.
    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_out_valid)
        else $error("accepted tick produced no result");

endmodule
